// ===== hdl/mwh_pkg.sv =====
// ----------------------------------------------------------------------------
// mwh_pkg
// Shared constants, codes and the queue entry type for the word hash.
// ----------------------------------------------------------------------------
package mwh_pkg;

  localparam logic [31:0] MIX_MULT      = 32'h5bd1_e995;
  localparam int          WORD_SHIFT    = 24;
  localparam int          FINAL_SHIFT_A = 13;
  localparam int          FINAL_SHIFT_B = 15;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;
  localparam int OCC_W  = 4;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_TAIL = 2'd1;
  localparam logic [1:0] KIND_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] kval;
    logic        first;
    logic        last;
    logic [30:0] len;
  } mwh_entry_t;

endpackage

// ===== hdl/mwh_front.sv =====
// ----------------------------------------------------------------------------
// mwh_front
// Accept words, classify them and premix full words in two stages.
// ----------------------------------------------------------------------------
module mwh_front
  import mwh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [31:0]       in_key_word,
  input  logic [2:0]        in_valid_bytes,
  input  logic              in_last_word,
  input  logic [30:0]       in_key_len,
  input  logic [QCNT_W-1:0] q_count,
  output logic              push,
  output mwh_entry_t        push_entry
);

  logic        a_v_r;
  logic [1:0]  a_kind_r;
  logic [31:0] a_k_r;
  logic        a_first_r;
  logic        a_last_r;
  logic [30:0] a_len_r;
  logic        b_v_r;
  mwh_entry_t  b_entry_r;
  logic        first_r;

  logic [1:0]     a_kind_nxt;
  logic [31:0]    a_k_nxt;
  logic [31:0]    b_mix;
  logic [31:0]    b_k_nxt;
  logic [OCC_W-1:0] occ;
  logic           accept;

  assign occ = OCC_W'(q_count) + OCC_W'(a_v_r) + OCC_W'(b_v_r);
  assign in_ready = (occ < OCC_W'(QDEPTH));
  assign accept = in_valid && in_ready;

  always_comb begin
    case (in_valid_bytes) inside
      3'd0: begin
        a_kind_nxt = KIND_NONE;
        a_k_nxt    = 32'd0;
      end
      3'd1: begin
        a_kind_nxt = KIND_TAIL;
        a_k_nxt    = {24'd0, in_key_word[7:0]};
      end
      3'd2: begin
        a_kind_nxt = KIND_TAIL;
        a_k_nxt    = {16'd0, in_key_word[15:0]};
      end
      3'd3: begin
        a_kind_nxt = KIND_TAIL;
        a_k_nxt    = {8'd0, in_key_word[23:0]};
      end
      default: begin
        a_kind_nxt = KIND_FULL;
        a_k_nxt    = in_key_word * MIX_MULT;
      end
    endcase
  end

  assign b_mix   = a_k_r ^ (a_k_r >> WORD_SHIFT);
  assign b_k_nxt = (a_kind_r == KIND_FULL) ? b_mix * MIX_MULT : a_k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      b_v_r   <= 1'b0;
      first_r <= 1'b1;
    end else begin
      a_v_r <= accept;
      b_v_r <= a_v_r;
      if (accept) begin
        first_r <= in_last_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_kind_r  <= a_kind_nxt;
      a_k_r     <= a_k_nxt;
      a_first_r <= first_r;
      a_last_r  <= in_last_word;
      a_len_r   <= in_key_len;
    end
    if (a_v_r) begin
      b_entry_r.kind  <= a_kind_r;
      b_entry_r.kval  <= b_k_nxt;
      b_entry_r.first <= a_first_r;
      b_entry_r.last  <= a_last_r;
      b_entry_r.len   <= a_len_r;
    end
  end

  assign push       = b_v_r;
  assign push_entry = b_entry_r;

endmodule

// ===== hdl/mwh_queue.sv =====
// ----------------------------------------------------------------------------
// mwh_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module mwh_queue
  import mwh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mwh_entry_t        push_entry,
  input  logic              pop,
  output mwh_entry_t        head_entry,
  output logic [QCNT_W-1:0] count
);

  mwh_entry_t        slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  assign head_entry = slot_r[rd_ptr_r];
  assign count      = count_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> count_r < QCNT_W'(QDEPTH))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("queue underflow");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    push == pop |=> $stable(count_r))
    else $error("queue count moved without net traffic");

endmodule

// ===== hdl/mwh_back.sv =====
// ----------------------------------------------------------------------------
// mwh_back
// Fold queued words into the running hash, run the avalanche, hold result.
// ----------------------------------------------------------------------------
module mwh_back
  import mwh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [31:0]       cfg_wr_data,
  input  mwh_entry_t        head_entry,
  input  logic [QCNT_W-1:0] q_count,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       out_digest
);

  logic [31:0] seed_r;
  logic [31:0] run_hash_r;
  logic        av_v_r;
  logic [31:0] av_h_r;
  logic        out_v_r;
  logic [31:0] out_h_r;

  logic [31:0] h_start;
  logic [31:0] h_nxt;
  logic [31:0] av_mix;
  logic [31:0] av_prod;
  logic        out_load;
  logic        av_free;

  assign out_load = av_v_r && (!out_v_r || out_ready);
  assign av_free  = !av_v_r || out_load;
  assign pop      = (q_count != '0) && (!head_entry.last || av_free);

  assign h_start = head_entry.first ? (seed_r ^ {1'b0, head_entry.len}) : run_hash_r;

  always_comb begin
    case (head_entry.kind)
      KIND_FULL: h_nxt = (h_start * MIX_MULT) ^ head_entry.kval;
      KIND_TAIL: h_nxt = (h_start ^ head_entry.kval) * MIX_MULT;
      default:   h_nxt = h_start;
    endcase
  end

  assign av_mix  = av_h_r ^ (av_h_r >> FINAL_SHIFT_A);
  assign av_prod = av_mix * MIX_MULT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r     <= '0;
      run_hash_r <= '0;
      av_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
      if (pop) begin
        run_hash_r <= h_nxt;
      end
      if (pop && head_entry.last) begin
        av_v_r <= 1'b1;
      end else if (out_load) begin
        av_v_r <= 1'b0;
      end
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_entry.last) begin
      av_h_r <= h_nxt;
    end
    if (out_load) begin
      out_h_r <= av_prod ^ (av_prod >> FINAL_SHIFT_B);
    end
  end

  assign out_valid  = out_v_r;
  assign out_digest = out_h_r;

  a_av_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    av_v_r && !out_load |=> av_v_r && $stable(av_h_r))
    else $error("avalanche stage lost a hash");

  a_last_pop_room: assert property (@(posedge clk) disable iff (!rst_n)
    pop && head_entry.last |-> av_free)
    else $error("last word popped with avalanche stage busy");

  a_out_from_av: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(av_v_r))
    else $error("result appeared without an avalanche hash");

endmodule

// ===== hdl/murmur2_word_hash.sv =====
// ----------------------------------------------------------------------------
// murmur2_word_hash
// Streaming 32-bit MurmurHash2 over little-endian key words.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  in       input      in_valid / in_ready   key_word, valid_bytes, last_word,
//                                            key_len
//  out      output     out_valid / out_ready digest
//  cfg      input      cfg_wr_en             cfg_wr_data (seed)
//
//  One word per cycle sustained while the output keeps up; the single 32-bit
//  multiply per word in the back part's hash recurrence sets that figure.
//  The last word passes the two front stages, the queue, the avalanche
//  register and the output register before out_valid rises.
//  Reset clears the queue, the running hash, the seed and the output.
//  The four-entry queue lets a stalled output hold the back part while the
//  front keeps taking words until the queue fills.
// ----------------------------------------------------------------------------
module murmur2_word_hash
  import mwh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_key_word,
  input  logic [2:0]  in_valid_bytes,
  input  logic        in_last_word,
  input  logic [30:0] in_key_len,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest
);

  logic              push;
  mwh_entry_t        push_entry;
  logic              pop;
  mwh_entry_t        head_entry;
  logic [QCNT_W-1:0] q_count;

  mwh_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_key_word    (in_key_word),
    .in_valid_bytes (in_valid_bytes),
    .in_last_word   (in_last_word),
    .in_key_len     (in_key_len),
    .q_count        (q_count),
    .push           (push),
    .push_entry     (push_entry)
  );

  mwh_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_entry (head_entry),
    .count      (q_count)
  );

  mwh_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .head_entry  (head_entry),
    .q_count     (q_count),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_digest  (out_digest)
  );

endmodule

// ===== test/murmur2_word_hash_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// murmur2_word_hash_test
// Feeds keys through the word hash and checks every hash it returns.
// A short directed set covers empty keys, tails, oversized and zero valid
// counts and length mismatches. Phases of random keys and noise words follow,
// each under its own seed. Each accepted word updates a local hash model, and
// returned hashes are compared in order against the queue it fills. Both sides
// idle in random bursts, and one long output hold-off backs up the input.
// ----------------------------------------------------------------------------
module murmur2_word_hash_test;

  localparam logic [31:0] HASH_MULT   = 32'h5bd1_e995;
  localparam int          STALL_LIMIT = 2000;
  localparam int          HOLD_CYCLES = 300;
  localparam int          PHASE_WORDS = 300;

  typedef struct packed {
    logic [31:0] key_word;
    logic [2:0]  valid_bytes;
    logic        last_word;
    logic [30:0] key_len;
  } hash_in_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_key_word = '0;
  logic [2:0]  in_valid_bytes = '0;
  logic        in_last_word = 1'b0;
  logic [30:0] in_key_len = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_digest;

  hash_in_t    word_q[$];
  logic [31:0] hash_q[$];
  hash_in_t    drive_word;

  logic [31:0] seed_reg = '0;
  logic [31:0] run_hash = '0;
  logic        new_key = 1'b1;

  bit          calm = 1'b0;
  int unsigned queued_words = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned idle_cycles = 0;
  int unsigned mismatch_cnt = 0;

  murmur2_word_hash dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_key_word   (in_key_word),
    .in_valid_bytes(in_valid_bytes),
    .in_last_word  (in_last_word),
    .in_key_len    (in_key_len),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_digest    (out_digest)
  );

  always #1 clk = ~clk;

  function automatic void absorb_word(input hash_in_t w);
    logic [31:0] h;
    logic [31:0] k;
    logic [31:0] mask;
    logic [2:0]  n;
    n = (w.valid_bytes > 3'd4) ? 3'd4 : w.valid_bytes;
    h = new_key ? (seed_reg ^ {1'b0, w.key_len}) : run_hash;
    case (n)
      3'd4: begin
        k = w.key_word * HASH_MULT;
        k ^= k >> 24;
        k = k * HASH_MULT;
        h = (h * HASH_MULT) ^ k;
      end
      3'd0: ;
      default: begin
        mask = 32'hFFFF_FFFF >> (8 * (4 - n));
        h = (h ^ (w.key_word & mask)) * HASH_MULT;
      end
    endcase
    run_hash = h;
    new_key = w.last_word;
    if (w.last_word) begin
      h ^= h >> 13;
      h = h * HASH_MULT;
      h ^= h >> 15;
      hash_q.push_back(h);
    end
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("hash mismatch (%s): expected %08h, got %08h", what, want, got);
  endtask

  task automatic queue_word(input logic [31:0] kw, input logic [2:0] vb,
                            input logic lw, input logic [30:0] len);
    hash_in_t w;
    w.key_word    = kw;
    w.valid_bytes = vb;
    w.last_word   = lw;
    w.key_len     = len;
    word_q.push_back(w);
    queued_words++;
  endtask

  task automatic queue_key(input int unsigned nbytes, input logic [30:0] len_field);
    int unsigned left;
    logic [2:0]  vb;
    bit          first;
    left = nbytes;
    first = 1'b1;
    if (nbytes == 0) begin
      queue_word($urandom, 3'd0, 1'b1, len_field);
      return;
    end
    while (left > 0) begin
      vb = (left >= 4) ? 3'd4 : 3'(left);
      if (vb == 3'd4 && $urandom_range(0, 9) == 0)
        vb = 3'($urandom_range(5, 7));
      left -= (left >= 4) ? 4 : left;
      queue_word($urandom, vb, left == 0, first ? len_field : 31'($urandom));
      first = 1'b0;
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (word_q.size() != 0 || in_valid || hash_q.size() != 0);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_seed(input logic [31:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    seed_reg = v;
    @(negedge clk);
  endtask

  // sender: advance on acceptance, idle in bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        absorb_word(drive_word);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(0, 7);
          in_valid <= 1'b0;
        end else if (word_q.size() > 0) begin
          drive_word = word_q.pop_front();
          in_valid       <= 1'b1;
          in_key_word    <= drive_word.key_word;
          in_valid_bytes <= drive_word.valid_bytes;
          in_last_word   <= drive_word.last_word;
          in_key_len     <= drive_word.key_len;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: long hold-off on request, otherwise stall in bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (hash_q.size() == 0)
        note_mismatch("no hash pending", 32'h0, out_digest);
      else if (hash_q[0] !== out_digest)
        note_mismatch("digest", hash_q.pop_front(), out_digest);
      else
        void'(hash_q.pop_front());
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] seeds[5];
    int unsigned target;
    int unsigned nbytes;
    seeds = '{32'hFFFF_FFFF, 32'h0000_0000, $urandom, 32'h8000_0001, $urandom};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty keys, tails with junk above them, full words, oversized counts
    queue_word(32'h0000_0000, 3'd0, 1'b1, 31'd0);
    queue_word(32'hFFFF_FFFF, 3'd0, 1'b1, 31'h7FFF_FFFF);
    queue_word(32'hFFFF_FFFF, 3'd1, 1'b1, 31'd1);
    queue_word(32'hFFFF_FFFF, 3'd2, 1'b1, 31'd2);
    queue_word(32'hFFFF_FFFF, 3'd3, 1'b1, 31'd3);
    queue_word(32'h0000_0000, 3'd4, 1'b1, 31'd4);
    queue_word(32'hFFFF_FFFF, 3'd4, 1'b1, 31'd4);
    queue_word(32'hA5A5_5A5A, 3'd5, 1'b1, 31'd4);
    queue_word(32'hA5A5_5A5A, 3'd6, 1'b1, 31'd4);
    queue_word(32'hA5A5_5A5A, 3'd7, 1'b1, 31'd4);
    // partial word in the middle of a key
    queue_word(32'h1234_5678, 3'd2, 1'b0, 31'd6);
    queue_word(32'h9ABC_DEF0, 3'd4, 1'b1, 31'd0);
    // zero valid bytes opening a key, then mid-key
    queue_word(32'hFFFF_FFFF, 3'd0, 1'b0, 31'd7);
    queue_word(32'h0102_0304, 3'd3, 1'b1, 31'd0);
    queue_word(32'hDEAD_BEEF, 3'd4, 1'b0, 31'd9);
    queue_word(32'hFFFF_FFFF, 3'd0, 1'b0, 31'd0);
    queue_word(32'h0000_00FF, 3'd1, 1'b1, 31'd0);
    // length that disagrees with the words sent
    queue_word(32'hC0FF_EE00, 3'd4, 1'b1, 31'd100);
    queue_word(32'hFFFF_FFFF, 3'd4, 1'b0, 31'd8);
    queue_word(32'hFFFF_FFFF, 3'd4, 1'b1, 31'h5555_5555);

    for (int p = 0; p < 5; p++) begin
      wait_idle();
      write_seed(seeds[p]);
      calm = (p == 4);
      if (p == 1)
        hold_req++;
      target = queued_words + PHASE_WORDS;
      while (queued_words < target) begin
        if ($urandom_range(0, 6) == 0) begin
          queue_word($urandom, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                     31'($urandom));
        end else begin
          nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
                                               : $urandom_range(0, 16);
          queue_key(nbytes, ($urandom_range(0, 6) == 0) ? 31'($urandom) : 31'(nbytes));
        end
      end
      // close any key left open by a noise word
      nbytes = $urandom_range(0, 8);
      queue_key(nbytes, 31'(nbytes));
    end

    wait_idle();
    if (mismatch_cnt == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
